// File: hdl/spd_pkg.sv
// Shared constants and types for the shortest path block.
package spd_pkg;
	localparam int unsigned MaxNodesDefault = 64;
	localparam int unsigned MaxEdgesDefault = 512;
	localparam int unsigned DistW = 26;
	localparam int unsigned WeightW = 20;
	localparam int unsigned NodeW = 7;
	localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_SOLVE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	localparam logic CFG_NODE_COUNT = 1'b0;
	localparam logic CFG_SOURCE = 1'b1;
endpackage

// File: hdl/shortest_path_dijkstra_top.sv
// Top level of the single-source shortest path block (Dijkstra).
//
// Usage:
//  - Issue an item by raising start while busy is low; opcode selects the work.
//    OP_ADD stores the edge (node_a, node_b, weight) while the store has room;
//    OP_CLEAR empties the edge store and the overflow flag.
//  - OP_SOLVE searches from source_node and emits the path to node node_count
//    (0 acts as 1, clamped to MAX_NODES), one node per strobe, last on the final
//    one; an unreachable target gives one strobe with unreachable and last set.
//  - Registers are written through cfg_valid/cfg_ready (index 0 node_count,
//    index 1 source_node); the user must write them only while the block is
//    idle, as the block itself does not enforce this. cfg_ready is always high.
//  - Add and clear leave busy low, so items may follow back to back.
//  - A solve holds busy until its path is emitted. Each settle step scans the
//    node memory one entry a cycle, then reads every stored edge and, for each
//    edge that touches the settled node, reads and relaxes the neighbour's
//    entry; the path is then walked back through the parent entries and
//    emitted from the source end.
// Reset clears the edge count, overflow flag and control; memories need no
// clearing. The receiver cannot stall: every strobe is taken.
module shortest_path_dijkstra_top
	import spd_pkg::*;
#(
	parameter int unsigned MAX_NODES = MaxNodesDefault,
	parameter int unsigned MAX_EDGES = MaxEdgesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          opcode,
	input  logic [NodeW-1:0]    node_a,
	input  logic [NodeW-1:0]    node_b,
	input  logic [WeightW-1:0]  weight,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [NodeW-1:0]    cfg_data,
	output logic                strobe,
	output logic [NodeW-1:0]    path_node,
	output logic [DistW-1:0]    path_distance,
	output logic                last,
	output logic                unreachable,
	output logic                edge_overflow
);
	localparam int unsigned NiW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned EiW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int unsigned EcW = $clog2(MAX_EDGES + 1);
	localparam int unsigned EntW = 2 * NiW + WeightW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_SCAN, ST_SCAN_LAST, ST_EDGE_RD, ST_EDGE_CHK,
		ST_NODE_RD, ST_RELAX, ST_TGT, ST_PATH_RD, ST_PATH_WAIT, ST_PATH_EMIT,
		ST_PATH_NRD, ST_OUT
	} state_t;

	// Node memory entry: distance and parent (parent 0 = none).
	typedef struct packed {
		logic [DistW-1:0] cost;
		logic [NodeW-1:0] parent;
	} node_ent_t;

	logic [EntW-1:0]       edge_mem [MAX_EDGES];
	node_ent_t             node_mem [MAX_NODES];
	logic [EntW-1:0]       edge_rd;
	node_ent_t             node_rd;

	logic [MAX_NODES-1:0]  reached_q, settled_q;
	logic [EcW-1:0]        edge_count_q;
	logic                  overflow_q;
	logic [NodeW-1:0]      node_count_q, source_q;
	state_t                state_q;

	logic [NodeW-1:0]      n_eff;
	logic                  src_ok;
	logic [NiW-1:0]        scan_q, best_q, nbr_q;
	logic                  best_ok_q;
	logic [DistW-1:0]      best_dist_q, cand_q;
	logic [EcW-1:0]        eidx_q;
	logic [NodeW-1:0]      path_q [MAX_NODES];
	logic [NodeW-1:0]      path_rd_q;
	logic [NodeW:0]        plen_q, pemit_q;
	logic [NodeW-1:0]      cur_q;
	logic [NiW-1:0]        pidx;
	logic                  emit_last;

	// Edge memory control
	logic                  e_we;
	logic [EiW-1:0]        e_wa, e_ra;
	logic [EntW-1:0]       e_wd;
	// Node memory control
	logic                  n_we;
	logic [NiW-1:0]        n_wa, n_ra;
	node_ent_t             n_wd;

	always_comb begin
		if (node_count_q == '0) n_eff = NodeW'(1);
		else if (32'(node_count_q) > MAX_NODES) n_eff = NodeW'(MAX_NODES);
		else n_eff = node_count_q;
	end
	assign src_ok = (source_q != '0) && (source_q <= n_eff);
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (e_we) edge_mem[e_wa] <= e_wd;
		edge_rd <= edge_mem[e_ra];
	end
	always_ff @(posedge clk) begin
		if (n_we) node_mem[n_wa] <= n_wd;
		node_rd <= node_mem[n_ra];
	end

	// Path buffer: target first; read back from the source end.
	assign pidx = NiW'(plen_q - pemit_q - (NodeW+1)'(1));
	assign emit_last = (pemit_q + (NodeW+1)'(1) == plen_q);
	always_ff @(posedge clk) begin
		if (state_q == ST_PATH_RD) path_q[plen_q[NiW-1:0]] <= cur_q;
		path_rd_q <= path_q[pidx];
	end

	// Edge endpoint decode from the registered read word.
	logic [NiW-1:0]     ea, eb;
	logic [WeightW-1:0] ew;
	logic               e_use, e_hit;
	logic [NiW-1:0]     e_other;
	assign ea = edge_rd[NiW-1:0];
	assign eb = edge_rd[2*NiW-1:NiW];
	assign ew = edge_rd[EntW-1:2*NiW];
	assign e_use = (NodeW'(ea) < n_eff) && (NodeW'(eb) < n_eff);
	assign e_hit = e_use && ((ea == best_q) || (eb == best_q));
	assign e_other = (ea == best_q) ? eb : ea;

	logic [DistW:0] sum;
	assign sum = {1'b0, best_dist_q} + (DistW+1)'(ew);

	logic add_ok;
	assign add_ok = (node_a != '0) && (32'(node_a) <= MAX_NODES) &&
		(node_b != '0) && (32'(node_b) <= MAX_NODES);

	always_comb begin
		e_we = 1'b0;
		e_wa = edge_count_q[EiW-1:0];
		e_wd = {weight, NiW'(node_b - NodeW'(1)), NiW'(node_a - NodeW'(1))};
		e_ra = eidx_q[EiW-1:0];
		if (state_q == ST_IDLE && start && opcode_t'(opcode) == OP_ADD && add_ok &&
			32'(edge_count_q) < MAX_EDGES)
			e_we = 1'b1;
		n_we = 1'b0;
		n_wa = nbr_q;
		n_wd = '{cost: cand_q, parent: NodeW'(best_q) + NodeW'(1)};
		n_ra = scan_q;
		unique case (state_q)
			ST_INIT: begin
				n_we = src_ok;
				n_wa = NiW'(source_q - NodeW'(1));
				n_wd = '{cost: '0, parent: '0};
			end
			ST_EDGE_CHK: n_ra = e_other;
			ST_NODE_RD: n_ra = nbr_q;
			ST_RELAX: n_we = !reached_q[nbr_q] || (cand_q < node_rd.cost);
			ST_TGT, ST_PATH_RD, ST_PATH_WAIT: n_ra = NiW'(cur_q - NodeW'(1));
			ST_PATH_NRD: n_ra = NiW'(path_rd_q - NodeW'(1));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			edge_count_q <= '0;
			overflow_q <= 1'b0;
			node_count_q <= NodeW'(64);
			source_q <= NodeW'(1);
			reached_q <= '0;
			settled_q <= '0;
			strobe <= 1'b0;
			path_node <= '0;
			path_distance <= '0;
			last <= 1'b0;
			unreachable <= 1'b0;
			edge_overflow <= 1'b0;
			scan_q <= '0;
			best_q <= '0;
			nbr_q <= '0;
			best_ok_q <= 1'b0;
			best_dist_q <= '0;
			cand_q <= '0;
			eidx_q <= '0;
			plen_q <= '0;
			pemit_q <= '0;
			cur_q <= '0;
		end else begin
			strobe <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == CFG_NODE_COUNT) node_count_q <= cfg_data;
				else source_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (opcode_t'(opcode))
							OP_ADD: if (add_ok) begin
								if (32'(edge_count_q) < MAX_EDGES)
									edge_count_q <= edge_count_q + EcW'(1);
								else overflow_q <= 1'b1;
							end
							OP_CLEAR: begin
								edge_count_q <= '0;
								overflow_q <= 1'b0;
							end
							OP_SOLVE: begin
								reached_q <= '0;
								settled_q <= '0;
								state_q <= ST_INIT;
							end
							default: ;
						endcase
					end
				end
				ST_INIT: begin
					// Seed the source, then start the first min scan.
					if (src_ok) reached_q[NiW'(source_q - NodeW'(1))] <= 1'b1;
					scan_q <= '0;
					best_ok_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN, ST_SCAN_LAST: begin
					// node_rd holds entry scan_q-1 once past the first cycle, and entry scan_q in ST_SCAN_LAST.
					if (state_q == ST_SCAN_LAST || scan_q != '0) begin
						logic [NiW-1:0] idx;
						idx = (state_q == ST_SCAN_LAST) ? scan_q : scan_q - NiW'(1);
						if (reached_q[idx] && !settled_q[idx] &&
							(!best_ok_q || node_rd.cost < best_dist_q)) begin
							best_ok_q <= 1'b1;
							best_q <= idx;
							best_dist_q <= node_rd.cost;
						end
					end
					if (state_q == ST_SCAN) begin
						if (NodeW'(scan_q) + NodeW'(1) >= n_eff) state_q <= ST_SCAN_LAST;
						else scan_q <= scan_q + NiW'(1);
					end else state_q <= ST_EDGE_RD;
				end
				ST_EDGE_RD: begin
					if (state_q == ST_EDGE_RD && eidx_q == '0 && !best_ok_q) begin
						cur_q <= n_eff;
						state_q <= ST_TGT;
					end else begin
						if (eidx_q == '0) settled_q[best_q] <= 1'b1;
						if (eidx_q >= edge_count_q) begin
							eidx_q <= '0;
							scan_q <= '0;
							best_ok_q <= 1'b0;
							state_q <= ST_SCAN;
						end else state_q <= ST_EDGE_CHK;
					end
				end
				ST_EDGE_CHK: begin
					eidx_q <= eidx_q + EcW'(1);
					if (e_hit) begin
						nbr_q <= e_other;
						cand_q <= sum[DistW] ? DistMax : sum[DistW-1:0];
						state_q <= ST_NODE_RD;
					end else state_q <= ST_EDGE_RD;
				end
				ST_NODE_RD: state_q <= ST_RELAX;
				ST_RELAX: begin
					if (!reached_q[nbr_q] || cand_q < node_rd.cost)
						reached_q[nbr_q] <= 1'b1;
					state_q <= ST_EDGE_RD;
				end
				ST_TGT: begin
					plen_q <= '0;
					if (!reached_q[NiW'(n_eff - NodeW'(1))]) begin
						strobe <= 1'b1;
						path_node <= '0;
						path_distance <= '0;
						last <= 1'b1;
						unreachable <= 1'b1;
						edge_overflow <= overflow_q;
						state_q <= ST_IDLE;
					end else state_q <= ST_PATH_RD;
				end
				ST_PATH_RD: begin
					// node_rd holds the entry of cur_q; record it and follow parent.
					plen_q <= plen_q + (NodeW+1)'(1);
					if (cur_q == source_q || node_rd.parent == '0 ||
						node_rd.parent > n_eff || 32'(plen_q) + 1 >= MAX_NODES) begin
						pemit_q <= '0;
						state_q <= ST_PATH_EMIT;
					end else begin
						cur_q <= node_rd.parent;
						state_q <= ST_PATH_WAIT;
					end
				end
				// Wait while the parent's entry is read.
				ST_PATH_WAIT: state_q <= ST_PATH_RD;
				ST_PATH_EMIT: state_q <= ST_PATH_NRD;
				ST_PATH_NRD: state_q <= ST_OUT;
				ST_OUT: begin
					strobe <= 1'b1;
					path_node <= path_rd_q;
					path_distance <= node_rd.cost;
					last <= emit_last;
					unreachable <= 1'b0;
					edge_overflow <= overflow_q;
					pemit_q <= pemit_q + (NodeW+1)'(1);
					state_q <= emit_last ? ST_IDLE : ST_PATH_EMIT;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(edge_count_q) <= MAX_EDGES);
	a_store_idle: assert property (@(posedge clk) disable iff (!arst_n)
		e_we |-> state_q == ST_IDLE);
	a_unr_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && unreachable |-> last && path_node == '0);
	a_strobe_state: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (state_q == ST_IDLE || state_q == ST_PATH_EMIT));
endmodule

// File: bench/tb_shortest_path_dijkstra_top.sv
// Self-checking testbench for the Dijkstra shortest path block.
module tb_shortest_path_dijkstra_top;
	import spd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NNodes = 64;
	localparam int NEdges = 512;

	typedef struct {
		opcode_t            op;
		logic [NodeW-1:0]   a;
		logic [NodeW-1:0]   b;
		logic [WeightW-1:0] w;
	} item_t;

	typedef struct {
		logic [NodeW-1:0] node;
		logic [DistW-1:0] cost;
		logic             last;
		logic             unr;
		logic             ovf;
	} hop_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          opcode;
	logic [NodeW-1:0]    node_a;
	logic [NodeW-1:0]    node_b;
	logic [WeightW-1:0]  weight;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	logic [NodeW-1:0]    cfg_data;
	logic                strobe;
	logic [NodeW-1:0]    path_node;
	logic [DistW-1:0]    path_distance;
	logic                last;
	logic                unreachable;
	logic                edge_overflow;

	shortest_path_dijkstra_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.node_a(node_a), .node_b(node_b), .weight(weight), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .path_node(path_node), .path_distance(path_distance),
		.last(last), .unreachable(unreachable), .edge_overflow(edge_overflow)
	);

	// Items waiting for the driver and path hops waiting for the block.
	item_t pending_items[$];
	hop_t  expected_hops[$];
	int    fail_count = 0;

	// Shadow copy of the block's graph and registers.
	logic [5:0]         graph_a[NEdges];
	logic [5:0]         graph_b[NEdges];
	logic [WeightW-1:0] graph_w[NEdges];
	int                 graph_edges = 0;
	logic               graph_ovf = 0;
	logic [NodeW-1:0]   reg_node_count = 7'd64;
	logic [NodeW-1:0]   reg_source = 7'd1;

	always #10 clk = ~clk;

	// Run the search on the shadow graph and queue the path the block should emit.
	task automatic predict_path();
		logic [DistW-1:0] node_cost[NNodes];
		logic [NodeW-1:0] parent[NNodes];
		bit               reached[NNodes];
		bit               settled[NNodes];
		int               route[$];
		int               n, src, best, cur, nxt, v;
		longint           d;
		hop_t             h;
		n = reg_node_count;
		src = reg_source;
		if (n < 1) n = 1;
		if (n > NNodes) n = NNodes;
		foreach (reached[i]) begin
			reached[i] = 0;
			settled[i] = 0;
			node_cost[i] = '0;
			parent[i] = '0;
		end
		if (src >= 1 && src <= n) begin
			reached[src-1] = 1;
		end
		forever begin
			best = -1;
			for (int i = 0; i < n; i++)
				if (reached[i] && !settled[i] && (best < 0 || node_cost[i] < node_cost[best]))
					best = i;
			if (best < 0) break;
			settled[best] = 1;
			for (int e = 0; e < graph_edges; e++) begin
				if (graph_a[e] >= n || graph_b[e] >= n) continue;
				if (graph_a[e] == best) v = graph_b[e];
				else if (graph_b[e] == best) v = graph_a[e];
				else continue;
				d = longint'(node_cost[best]) + graph_w[e];
				if (d > DistMax) d = DistMax;
				if (!reached[v] || d < node_cost[v]) begin
					reached[v] = 1;
					node_cost[v] = d[DistW-1:0];
					parent[v] = NodeW'(best + 1);
				end
			end
		end
		h.ovf = graph_ovf;
		if (!reached[n-1]) begin
			h.node = '0;
			h.cost = '0;
			h.last = 1;
			h.unr = 1;
			expected_hops = {expected_hops, h};
			return;
		end
		// Walk parents back from the target, then emit source first.
		cur = n;
		while (route.size() < NNodes) begin
			route.push_front(cur);
			if (cur == src) break;
			nxt = parent[(cur - 1) & 6'h3f];
			if (nxt < 1 || nxt > n) break;
			cur = nxt;
		end
		foreach (route[i]) begin
			h.node = NodeW'(route[i]);
			h.cost = node_cost[(route[i] - 1) & 6'h3f];
			h.last = (i == route.size() - 1);
			h.unr = 0;
			expected_hops = {expected_hops, h};
		end
	endtask

	task automatic apply_item(item_t it);
		case (it.op)
			OP_ADD: begin
				if (it.a >= 1 && it.a <= NNodes && it.b >= 1 && it.b <= NNodes) begin
					if (graph_edges >= NEdges) begin
						graph_ovf = 1;
					end else begin
						graph_a[graph_edges] = 6'(it.a - 1);
						graph_b[graph_edges] = 6'(it.b - 1);
						graph_w[graph_edges] = it.w;
						graph_edges++;
					end
				end
			end
			OP_SOLVE: predict_path();
			OP_CLEAR: begin
				graph_edges = 0;
				graph_ovf = 0;
			end
			default: ;
		endcase
	endtask

	// Driver: feed queued items in bursts with random gaps; hold while busy.
	int    gap_left = 0;
	int    burst_left = 0;
	item_t cur_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			opcode <= OP_NONE;
			node_a <= '0;
			node_b <= '0;
			weight <= '0;
		end else if (!(start && busy)) begin
			if (start) apply_item(cur_item);
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cur_item = pending_items.pop_front();
				opcode <= cur_item.op;
				node_a <= cur_item.a;
				node_b <= cur_item.b;
				weight <= cur_item.w;
				start <= 1'b1;
				if (burst_left == 0) begin
					// About one burst in three runs with no gap after it.
					burst_left = $urandom_range(1, 8);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end else begin
					burst_left--;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check each path hop against the oldest expected one; track register writes.
	always @(posedge clk) begin
		hop_t h;
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_NODE_COUNT) reg_node_count = cfg_data;
			else reg_source = cfg_data;
		end
		if (arst_n && strobe) begin
			if (expected_hops.size() == 0) begin
				$display("%0t: unexpected hop node=%0d dist=%0d", $time, path_node,
					path_distance);
				fail_count++;
			end else begin
				h = expected_hops.pop_front();
				if (path_node !== h.node || path_distance !== h.cost || last !== h.last ||
						unreachable !== h.unr || edge_overflow !== h.ovf) begin
					$display("%0t: mismatch expected node=%0d dist=%0d last=%0b unr=%0b ovf=%0b",
						$time, h.node, h.cost, h.last, h.unr, h.ovf);
					$display("%0t:          actual node=%0d dist=%0d last=%0b unr=%0b ovf=%0b",
						$time, path_node, path_distance, last, unreachable, edge_overflow);
					fail_count++;
				end
			end
		end
	end

	function automatic void push_item(opcode_t op, int a = 1, int b = 1, int w = 0);
		item_t it;
		it.op = op;
		it.a = NodeW'(a);
		it.b = NodeW'(b);
		it.w = WeightW'(w);
		pending_items = {pending_items, it};
	endfunction

	// Drain everything, then let the last add or clear settle.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() > 0 || start || busy || expected_hops.size() > 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		cfg_index <= idx;
		cfg_data <= NodeW'(value);
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_graph_regs(int n, int src);
		wait_idle();
		write_reg(CFG_NODE_COUNT, n);
		write_reg(CFG_SOURCE, src);
	endtask

	// Random edge inside the node count, with some spill past it and some noise.
	function automatic void push_random_edge(int n);
		int a, b, w, pick;
		pick = $urandom_range(0, 19);
		a = $urandom_range(1, n);
		b = $urandom_range(1, n);
		w = ($urandom_range(0, 3) == 0) ? ($urandom & 20'hfffff) : $urandom_range(0, 40);
		if (pick == 0) push_item(OP_NONE, $urandom & 7'h7f, $urandom & 7'h7f, $urandom);
		else if (pick == 1) push_item(OP_ADD, $urandom_range(65, 127), b, w);
		else if (pick == 2) push_item(OP_ADD, a, 0, w);
		else if (pick == 3) push_item(OP_ADD, a, (n + 1 > NNodes) ? NNodes : n + 1, w);
		else push_item(OP_ADD, a, b, w);
	endfunction

	initial begin
		int n, src, cnt;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: empty store, unused opcode, bad endpoints, chain 1-64.
		push_item(OP_SOLVE);
		push_item(OP_NONE, 127, 127, 20'hfffff);
		push_item(OP_ADD, 0, 5, 7);
		push_item(OP_ADD, 65, 3, 7);
		push_item(OP_ADD, 127, 1, 7);
		push_item(OP_ADD, 1, 64, 20'hfffff);
		push_item(OP_ADD, 64, 2, 0);
		push_item(OP_ADD, 2, 1, 0);
		push_item(OP_SOLVE);
		push_item(OP_ADD, 1, 64, 20'hfffff);
		push_item(OP_SOLVE);
		// Node count zero acts as one: source is the target.
		set_graph_regs(0, 1);
		push_item(OP_SOLVE);
		// Node count above range acts as the full size.
		set_graph_regs(127, 2);
		push_item(OP_SOLVE);
		// Source zero and source past the node count reach nothing.
		set_graph_regs(64, 0);
		push_item(OP_SOLVE);
		set_graph_regs(3, 5);
		push_item(OP_SOLVE);
		// Edges to node 64 stay stored but lie outside three nodes.
		set_graph_regs(3, 1);
		push_item(OP_ADD, 2, 3, 5);
		push_item(OP_ADD, 3, 3, 1);
		push_item(OP_SOLVE);
		push_item(OP_CLEAR);
		push_item(OP_SOLVE);

		// Fill the store past capacity, then check the flag clears.
		set_graph_regs(2, 2);
		for (int i = 0; i < NEdges + 3; i++)
			push_item(OP_ADD, $urandom_range(1, 3), $urandom_range(1, 3), $urandom);
		push_item(OP_SOLVE);
		push_item(OP_CLEAR);
		push_item(OP_ADD, 2, 1, 9);
		push_item(OP_SOLVE);

		// Random graphs: clear, load edges, solve, add a few more, solve again.
		cnt = 0;
		while (cnt < 150) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 12);
			src = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 70) : $urandom_range(1, n);
			set_graph_regs(n, src);
			push_item(OP_CLEAR);
			for (int i = $urandom_range(0, 2 * n + 2); i > 0; i--) begin
				push_random_edge(n);
				cnt++;
			end
			push_item(OP_SOLVE);
			for (int i = $urandom_range(0, 4); i > 0; i--) begin
				push_random_edge(n);
				cnt++;
			end
			push_item(OP_SOLVE);
			cnt += 3;
		end
		set_graph_regs(64, 64);
		push_item(OP_SOLVE);

		wait_idle();
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

// File: shortest_path_dijkstra_top.f
hdl/spd_pkg.sv
hdl/shortest_path_dijkstra_top.sv
bench/tb_shortest_path_dijkstra_top.sv
